// ===== rtl/top_k_mean_curvature_select_macros.svh =====
// Assertion macros for the RTL file that checks its own logic.
// Both macros expect signals named clk and rst_n in the scope of use.
`ifndef TOP_K_MEAN_CURVATURE_SELECT_MACROS_SVH
`define TOP_K_MEAN_CURVATURE_SELECT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define TKMC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// The condition must never be true outside reset.
`define TKMC_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/tkmc_pkg.sv =====
package tkmc_pkg;

    localparam int KEEP_W = 11;
    localparam int CURV_W = 24;
    localparam int INDEX_W = 10;
    localparam int MAX_POINTS_DEF = 1024;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 11'd16;

    // Operation codes of an input word.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Status of the scan unit toward the controller.
    typedef struct packed {
        logic done;
        logic found;
    } scan_status_t;

endpackage

// ===== rtl/tkmc_channels.sv =====
interface tkmc_item_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic                                start_set;
    logic signed [tkmc_pkg::CURV_W-1:0]  principal_one;
    logic signed [tkmc_pkg::CURV_W-1:0]  principal_two;

    modport source (output valid, output operation, output start_set,
                    output principal_one, output principal_two, input ready);
    modport sink (input valid, input operation, input start_set,
                  input principal_one, input principal_two, output ready);
endinterface

interface tkmc_result_if;
    logic                                valid;
    logic                                ready;
    logic                                result_valid;
    logic [tkmc_pkg::INDEX_W-1:0]        point_index;
    logic signed [tkmc_pkg::CURV_W-1:0]  mean_curvature;
    logic                                last_of_run;

    modport source (output valid, output result_valid, output point_index,
                    output mean_curvature, output last_of_run, input ready);
    modport sink (input valid, input result_valid, input point_index,
                  input mean_curvature, input last_of_run, output ready);
endinterface

interface tkmc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tkmc_pkg::KEEP_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tkmc_store.sv =====
module tkmc_store #(
    parameter int DEPTH = tkmc_pkg::MAX_POINTS_DEF,
    parameter int WIDTH = tkmc_pkg::CURV_W + 1
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Simple dual-port memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tkmc_scan.sv =====
module tkmc_scan #(
    parameter int MAX_POINTS = tkmc_pkg::MAX_POINTS_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    input  logic [$clog2(MAX_POINTS + 1)-1:0]                 count,
    output logic                                              rd_en,
    output logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] rd_addr,
    input  logic [tkmc_pkg::CURV_W:0]                         rd_data,
    output tkmc_pkg::scan_status_t                            status,
    output logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] best_idx,
    output logic signed [tkmc_pkg::CURV_W-1:0]                best_val
);

    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CURV_W = tkmc_pkg::CURV_W;

    logic                      active_reg, active_next;
    logic [CNT_W-1:0]          issue_idx_reg, issue_idx_next;
    logic                      pend_reg, pend_next;
    logic                      found_reg, found_next;
    logic [ADDR_W-1:0]         pend_idx_reg;
    logic [ADDR_W-1:0]         best_idx_reg;
    logic signed [CURV_W-1:0]  best_val_reg;
    logic                      issuing;
    logic                      done;
    logic                      better;
    logic signed [CURV_W-1:0]  rd_mean;

    assign rd_mean = rd_data[CURV_W-1:0];
    assign issuing = active_reg && (issue_idx_reg < count);
    assign done = active_reg && !issuing && !pend_reg;

    // Strict compare keeps the earlier index when two means are equal.
    assign better = pend_reg && !rd_data[CURV_W]
                    && (!found_reg || (rd_mean > best_val_reg));

    always_comb
    begin
        active_next = active_reg;
        issue_idx_next = issue_idx_reg;
        found_next = found_reg;
        pend_next = issuing;
        if (start)
        begin
            active_next = 1'b1;
            issue_idx_next = '0;
            found_next = 1'b0;
        end
        else
        begin
            if (done)
            begin
                active_next = 1'b0;
            end
            if (issuing)
            begin
                issue_idx_next = issue_idx_reg + CNT_W'(1);
            end
            if (better)
            begin
                found_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            issue_idx_reg <= '0;
            pend_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            issue_idx_reg <= issue_idx_next;
            pend_reg <= pend_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issuing)
        begin
            pend_idx_reg <= issue_idx_reg[ADDR_W-1:0];
        end
        if (better)
        begin
            best_idx_reg <= pend_idx_reg;
            best_val_reg <= rd_mean;
        end
    end

    assign rd_en = issuing;
    assign rd_addr = issue_idx_reg[ADDR_W-1:0];
    assign status.done = done;
    assign status.found = found_reg;
    assign best_idx = best_idx_reg;
    assign best_val = best_val_reg;

endmodule

// ===== rtl/top_k_mean_curvature_select.sv =====
// Ranked readout of stored mean curvatures, largest first.
// The item channel takes one word per cycle while the block is idle. A load
// word (operation 0) stores the floor mean of its two curvatures at the next
// arrival index; start_set on a load first empties the set. A full store
// ignores further loads without start_set. A read word (operation 1)
// produces exactly one result word: the largest mean not yet reported, with
// its index, lower index first among equal means, or a word with result_valid
// low once keep_count results or all loaded points have been reported.
// For a read, the scan reads one memory entry per cycle through the single
// read port, then writes the taken mark back before the result word is valid
// and the item channel is ready again. An exhausted read skips the scan. The
// cfg channel is always ready and writes keep_count; it is to be written only
// while the block is idle. Reset empties the set and sets keep_count to 16.
// The result sits in an output register, so the block keeps accepting loads
// and starts the next scan while the receiver stalls; it waits only when a
// second result is due.
module top_k_mean_curvature_select #(
    parameter int MAX_POINTS = tkmc_pkg::MAX_POINTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    tkmc_item_if.sink     item,
    tkmc_result_if.source result,
    tkmc_cfg_if.sink      cfg
);

`include "top_k_mean_curvature_select_macros.svh"

    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int KEEP_W = tkmc_pkg::KEEP_W;
    localparam int LIM_W = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
    localparam int CURV_W = tkmc_pkg::CURV_W;
    localparam int INDEX_W = tkmc_pkg::INDEX_W;
    localparam int MEM_W = CURV_W + 1;

    // Controller states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [KEEP_W-1:0]         keep_count_reg;
    logic [CNT_W-1:0]          loaded_count_reg, loaded_count_next;
    logic [CNT_W-1:0]          emitted_count_reg, emitted_count_next;

    // Result waiting for the output register, then the output register itself.
    logic                      pend_valid_reg;
    logic [INDEX_W-1:0]        pend_idx_reg;
    logic signed [CURV_W-1:0]  pend_mean_reg;
    logic                      pend_last_reg;
    logic                      out_valid_reg, out_valid_next;
    logic                      res_valid_reg;
    logic [INDEX_W-1:0]        res_idx_reg;
    logic signed [CURV_W-1:0]  res_mean_reg;
    logic                      res_last_reg;

    logic                      item_fire;
    logic                      load_fire;
    logic                      read_fire;
    logic [LIM_W-1:0]          limit;
    logic [LIM_W-1:0]          keep_ext;
    logic [LIM_W-1:0]          loaded_ext;
    logic [LIM_W-1:0]          emitted_ext;
    logic                      exhausted;
    logic                      is_last;
    logic [CNT_W-1:0]          load_base;
    logic                      load_room;
    logic signed [CURV_W:0]    curv_sum;
    logic signed [CURV_W-1:0]  curv_mean;
    logic                      scan_start;
    logic                      mark_wr;
    logic                      out_load;
    logic [31:0]               best_idx_wide;

    logic                      mem_wr_en;
    logic [ADDR_W-1:0]         mem_wr_addr;
    logic [MEM_W-1:0]          mem_wr_data;
    logic                      mem_rd_en;
    logic [ADDR_W-1:0]         mem_rd_addr;
    logic [MEM_W-1:0]          mem_rd_data;

    tkmc_pkg::scan_status_t    scan_stat;
    logic [ADDR_W-1:0]         best_idx;
    logic signed [CURV_W-1:0]  best_val;

    assign item.ready = (state_reg == S_IDLE);
    assign item_fire = item.valid && item.ready;
    assign load_fire = item_fire && (item.operation == tkmc_pkg::OP_LOAD);
    assign read_fire = item_fire && (item.operation == tkmc_pkg::OP_READ);

    // The selection ends at the smaller of keep_count and the points loaded.
    assign keep_ext = LIM_W'(keep_count_reg);
    assign loaded_ext = LIM_W'(loaded_count_reg);
    assign emitted_ext = LIM_W'(emitted_count_reg);
    assign limit = (keep_ext < loaded_ext) ? keep_ext : loaded_ext;
    assign exhausted = (emitted_ext >= limit);
    assign is_last = ((emitted_ext + LIM_W'(1)) == limit);
    assign scan_start = read_fire && !exhausted;

    // Floor of the mean is an arithmetic shift of the 25-bit sum.
    assign curv_sum = {item.principal_one[CURV_W-1], item.principal_one}
                      + {item.principal_two[CURV_W-1], item.principal_two};
    assign curv_mean = curv_sum[CURV_W:1];

    assign load_base = item.start_set ? '0 : loaded_count_reg;
    assign load_room = (load_base < CNT_W'(MAX_POINTS));

    // The winner's taken mark is written back when the scan finishes.
    assign mark_wr = (state_reg == S_SCAN) && scan_stat.done && scan_stat.found;
    assign best_idx_wide = 32'(best_idx);

    // Loads and mark write-backs never fall in the same cycle: loads are only
    // taken in the idle state. A new entry is stored with its mark clear, so
    // marks left beyond the loaded count never need clearing.
    always_comb
    begin
        mem_wr_en = 1'b0;
        mem_wr_addr = best_idx;
        mem_wr_data = {1'b1, best_val};
        if (load_fire && load_room)
        begin
            mem_wr_en = 1'b1;
            mem_wr_addr = load_base[ADDR_W-1:0];
            mem_wr_data = {1'b0, curv_mean};
        end
        else if (mark_wr)
        begin
            mem_wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        loaded_count_next = loaded_count_reg;
        emitted_count_next = emitted_count_reg;
        out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (load_fire)
                begin
                    if (item.start_set)
                    begin
                        emitted_count_next = '0;
                    end
                    loaded_count_next = load_room ? load_base + CNT_W'(1) : load_base;
                end
                else if (read_fire)
                begin
                    state_next = exhausted ? S_EMIT : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_stat.done)
                begin
                    state_next = S_EMIT;
                    if (scan_stat.found)
                    begin
                        emitted_count_next = emitted_count_reg + CNT_W'(1);
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            keep_count_reg <= tkmc_pkg::KEEP_RESET;
            loaded_count_reg <= '0;
            emitted_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            loaded_count_reg <= loaded_count_next;
            emitted_count_reg <= emitted_count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                keep_count_reg <= cfg.data;
            end
        end
    end

    // Pending result: an exhausted read or a scan without a winner reads as
    // all zero.
    always_ff @(posedge clk)
    begin
        if (read_fire && exhausted)
        begin
            pend_valid_reg <= 1'b0;
            pend_idx_reg <= '0;
            pend_mean_reg <= '0;
            pend_last_reg <= 1'b0;
        end
        else if ((state_reg == S_SCAN) && scan_stat.done)
        begin
            pend_valid_reg <= scan_stat.found;
            pend_idx_reg <= scan_stat.found ? best_idx_wide[INDEX_W-1:0] : '0;
            pend_mean_reg <= scan_stat.found ? best_val : '0;
            pend_last_reg <= scan_stat.found && is_last;
        end
        if (out_load)
        begin
            res_valid_reg <= pend_valid_reg;
            res_idx_reg <= pend_idx_reg;
            res_mean_reg <= pend_mean_reg;
            res_last_reg <= pend_last_reg;
        end
    end

    assign cfg.ready = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.result_valid = res_valid_reg;
    assign result.point_index = res_idx_reg;
    assign result.mean_curvature = res_mean_reg;
    assign result.last_of_run = res_last_reg;

    tkmc_store #(
        .DEPTH (MAX_POINTS),
        .WIDTH (MEM_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    tkmc_scan #(
        .MAX_POINTS (MAX_POINTS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scan_start),
        .count    (loaded_count_reg),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .rd_data  (mem_rd_data),
        .status   (scan_stat),
        .best_idx (best_idx),
        .best_val (best_val)
    );

    // Every reported point carries a mark, so reports never outnumber points.
    `TKMC_NEVER(a_emit_le_loaded, emitted_count_reg > loaded_count_reg, "emitted exceeds loaded")
    // The scan only finishes while the controller waits for it.
    `TKMC_ASSERT(a_done_in_scan, scan_stat.done |-> state_reg == S_SCAN, "scan done outside scan")
    // A finished scan always hands its result to the emit step.
    `TKMC_ASSERT(a_done_to_emit, scan_stat.done |=> state_reg == S_EMIT, "scan result not emitted")
    // A read word always leaves the idle state to produce its result.
    `TKMC_ASSERT(a_read_leaves_idle, read_fire |=> state_reg != S_IDLE, "read left no result")
    // A write-back of a mark always finds a winner with a loaded index.
    `TKMC_NEVER(a_mark_in_range, mark_wr && (CNT_W'(best_idx) >= loaded_count_reg), "bad mark index")

endmodule

// ===== test/top_k_mean_curvature_select_tb.sv =====
`timescale 1ns / 100ps

module top_k_mean_curvature_select_tb;

    localparam int CURV_W = tkmc_pkg::CURV_W;
    localparam int INDEX_W = tkmc_pkg::INDEX_W;
    localparam int KEEP_W = tkmc_pkg::KEEP_W;
    localparam int POINT_CAP = tkmc_pkg::MAX_POINTS_DEF;

    // A whole read scans every stored point, and receiver stalls come on top of that.
    // Nothing else keeps all three channels quiet for long.
    localparam int STALL_LIMIT = 6000;

    // The stimulus stops adding small random sets once this many words have gone in.
    localparam int SMALL_SET_WORDS = 555;

    localparam logic signed [CURV_W-1:0] CURV_MAX = {1'b0, {(CURV_W-1){1'b1}}};
    localparam logic signed [CURV_W-1:0] CURV_MIN = {1'b1, {(CURV_W-1){1'b0}}};

    // One result word as the receiver sees it.
    typedef struct packed {
        logic                     result_valid;
        logic [INDEX_W-1:0]       point_index;
        logic signed [CURV_W-1:0] mean_curvature;
        logic                     last_of_run;
    } ranked_word_t;

    // The ranking tracker keeps its own copy of the stored means, the taken marks
    // and the counters. From these it works out the word that each read must return.
    class curvature_rank_board;
        int unsigned              keep_limit;
        logic signed [CURV_W-1:0] mean_mem [POINT_CAP];
        bit                       taken [POINT_CAP];
        int unsigned              loaded;
        int unsigned              emitted;
        ranked_word_t             due [$];
        int unsigned              failures;

        function new();
            keep_limit = 32'(tkmc_pkg::KEEP_RESET);
            loaded = 0;
            emitted = 0;
            failures = 0;
            foreach (taken[i])
                taken[i] = 1'b0;
        endfunction

        // Called for every word that the item channel accepts.
        function void note_word(logic op, logic start, logic signed [CURV_W-1:0] p1,
                                logic signed [CURV_W-1:0] p2);
            int           sum;
            int unsigned  limit;
            int           best;
            bit           found;
            ranked_word_t word;
            if (op == tkmc_pkg::OP_LOAD)
            begin
                if (start)
                begin
                    foreach (taken[i])
                        taken[i] = 1'b0;
                    loaded = 0;
                    emitted = 0;
                end
                if (loaded < POINT_CAP)
                begin
                    sum = int'(p1) + int'(p2);
                    mean_mem[loaded] = CURV_W'(sum >>> 1);
                    taken[loaded] = 1'b0;
                    loaded++;
                end
                return;
            end
            word = '0;
            limit = (keep_limit < loaded) ? keep_limit : loaded;
            found = 1'b0;
            best = 0;
            if (emitted < limit)
            begin
                for (int i = 0; i < loaded; i++)
                begin
                    if (!taken[i] && (!found || mean_mem[i] > mean_mem[best]))
                    begin
                        found = 1'b1;
                        best = i;
                    end
                end
                if (found)
                begin
                    taken[best] = 1'b1;
                    emitted++;
                    word.result_valid = 1'b1;
                    word.point_index = INDEX_W'(best);
                    word.mean_curvature = mean_mem[best];
                    word.last_of_run = (emitted == limit);
                end
            end
            due.insert(due.size(), word);
        endfunction

        // Called for every word that the result channel delivers.
        function void check_word(ranked_word_t got);
            ranked_word_t want;
            if (due.size() == 0)
            begin
                $error("result word with none due: result_valid=%0d point_index=%0d",
                       got.result_valid, got.point_index);
                failures++;
                return;
            end
            want = due.pop_front();
            if (got.result_valid !== want.result_valid)
            begin
                $error("result_valid: expected %0d, got %0d",
                       want.result_valid, got.result_valid);
                failures++;
            end
            if (got.point_index !== want.point_index)
            begin
                $error("point_index: expected %0d, got %0d",
                       want.point_index, got.point_index);
                failures++;
            end
            if (got.mean_curvature !== want.mean_curvature)
            begin
                $error("mean_curvature: expected %0d, got %0d",
                       want.mean_curvature, got.mean_curvature);
                failures++;
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                $error("last_of_run: expected %0d, got %0d",
                       want.last_of_run, got.last_of_run);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tkmc_item_if   item_ch ();
    tkmc_result_if result_ch ();
    tkmc_cfg_if    cfg_ch ();

    top_k_mean_curvature_select uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    curvature_rank_board board;

    // While steady is set, neither side inserts idle cycles.
    bit          steady;
    int unsigned counted;
    int unsigned quiet_cycles;

    always #4 clk = ~clk;

    // The receiver changes ready at the falling edge. It stalls about a quarter of the
    // time, except inside the steady stretch.
    always @(negedge clk)
    begin
        result_ch.ready <= steady || ($urandom_range(0, 99) >= 25);
    end

    // Every delivered word is checked at the rising edge that moves it.
    always @(posedge clk)
    begin : result_monitor
        ranked_word_t seen;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            seen.result_valid = result_ch.result_valid;
            seen.point_index = result_ch.point_index;
            seen.mean_curvature = result_ch.mean_curvature;
            seen.last_of_run = result_ch.last_of_run;
            board.check_word(seen);
        end
    end

    // The watchdog trips when no channel has moved a word for too long.
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("top_k_mean_curvature_select verification failed");
            $finish;
        end
    end

    // Sizes a plain integer to a curvature field.
    function automatic logic signed [CURV_W-1:0] curv_of(int v);
        return CURV_W'(v);
    endfunction

    // Presents one word on the item channel and returns at the falling edge after
    // it is accepted. Valid stays high, so back-to-back words need no gap. Random
    // idle cycles come before the word, with junk on the payload.
    task automatic send_word(input logic op, input logic start,
                             input logic signed [CURV_W-1:0] p1,
                             input logic signed [CURV_W-1:0] p2);
        bit ignored;
        while (!steady && $urandom_range(0, 99) < 25)
        begin
            item_ch.valid <= 1'b0;
            item_ch.operation <= 1'($urandom_range(0, 1));
            item_ch.principal_one <= CURV_W'($urandom);
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.operation <= op;
        item_ch.start_set <= start;
        item_ch.principal_one <= p1;
        item_ch.principal_two <= p2;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        // A load without start_set into a full store is dropped by the block.
        // Such a word does not count toward the stimulus length.
        ignored = (op == tkmc_pkg::OP_LOAD) && !start && (board.loaded >= POINT_CAP);
        board.note_word(op, start, p1, p2);
        if (!ignored)
            counted++;
        steady = (counted >= 250 && counted < 350);
        @(negedge clk);
    endtask

    // Draws a curvature. Style 0 spans the full 24 bits. Style 1 uses a tiny pool,
    // so equal means are common and the lower-index rule gets exercised. Style 2
    // uses the extremes and the values around zero. Style 3 is a moderate range.
    function automatic logic signed [CURV_W-1:0] pick_curv(int style);
        logic signed [CURV_W-1:0] v;
        case (style)
            0: v = CURV_W'($urandom);
            1: v = curv_of(int'($urandom_range(0, 8)) - 4);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: v = CURV_MAX;
                    1: v = CURV_MIN;
                    2: v = '0;
                    3: v = curv_of(-1);
                    default: v = curv_of(1);
                endcase
            end
            default: v = curv_of(int'($urandom_range(0, 2000)) - 1000);
        endcase
        return v;
    endfunction

    task automatic send_load(input logic start, input int style);
        send_word(tkmc_pkg::OP_LOAD, start, pick_curv(style), pick_curv(style));
    endtask

    // A read carries junk curvatures and a random start flag. The block ignores both.
    task automatic send_read();
        send_word(tkmc_pkg::OP_READ, 1'($urandom_range(0, 1)), pick_curv(0), pick_curv(0));
    endtask

    // Brings the block to idle: the item channel goes quiet and every due result
    // comes back. A short pause then covers a trailing load still in flight.
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (board.due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_keep(input logic [KEEP_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        board.keep_limit = 32'(value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_directed();
        // This read comes before any load, so it must report an exhausted selection.
        send_word(tkmc_pkg::OP_READ, 1'b0, '0, '0);
        // Six points cover the largest mean, the smallest mean and a mean of minus one.
        // They also cover floor rounding of plus and minus one half. Two points tie
        // at minus one, at indices 2 and 4.
        send_word(tkmc_pkg::OP_LOAD, 1'b1, CURV_MAX, CURV_MAX);
        send_word(tkmc_pkg::OP_LOAD, 1'b0, CURV_MIN, CURV_MIN);
        send_word(tkmc_pkg::OP_LOAD, 1'b0, CURV_MAX, CURV_MIN);
        send_word(tkmc_pkg::OP_LOAD, 1'b0, curv_of(1), '0);
        send_word(tkmc_pkg::OP_LOAD, 1'b0, curv_of(-1), '0);
        send_word(tkmc_pkg::OP_LOAD, 1'b0, curv_of(3), curv_of(-1));
        // The block must ignore the start flag on a read.
        send_word(tkmc_pkg::OP_READ, 1'b1, '0, '0);
        repeat (6) send_word(tkmc_pkg::OP_READ, 1'b0, '0, '0);
        // An appended load joins the set that is already being read.
        send_word(tkmc_pkg::OP_LOAD, 1'b0, curv_of(5), curv_of(5));
        repeat (2) send_word(tkmc_pkg::OP_READ, 1'b0, '0, '0);
        // With a keep count of zero, every read is exhausted.
        settle();
        write_keep('0);
        send_word(tkmc_pkg::OP_LOAD, 1'b1, curv_of(100), curv_of(-300));
        send_word(tkmc_pkg::OP_LOAD, 1'b0, curv_of(-7), curv_of(2));
        repeat (2) send_word(tkmc_pkg::OP_READ, 1'b0, '0, '0);
    endtask

    // One set of points: its first load restarts the set, and now and then a later
    // load restarts it early. Reads follow, some of them past exhaustion, with stray
    // appended loads among them. Most sets are small so reads stay short.
    task automatic run_set();
        int unsigned n;
        int unsigned reads;
        int          style;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 20);
        style = int'($urandom_range(0, 3));
        send_load(1'b1, style);
        repeat (n - 1) send_load($urandom_range(0, 39) == 0, style);
        reads = $urandom_range(1, n + 3);
        repeat (reads)
        begin
            if ($urandom_range(0, 9) == 0)
                send_load(1'b0, style);
            send_read();
        end
    endtask

    task automatic run_random();
        int unsigned phase;
        int unsigned pick;
        logic [KEEP_W-1:0] keep;
        phase = 0;
        while (counted < SMALL_SET_WORDS)
        begin
            // The first two phases use a keep count of one and the largest value the
            // field can hold. Later phases draw the keep count, weighted toward small
            // values.
            pick = $urandom_range(0, 9);
            if (phase == 0)
                keep = 11'd1;
            else if (phase == 1)
                keep = '1;
            else if (pick == 0)
                keep = 11'd1;
            else if (pick == 1)
                keep = 11'd2;
            else if (pick == 2)
                keep = 11'd1024;
            else if (pick == 3)
                keep = '1;
            else if (pick == 4)
                keep = '0;
            else
                keep = KEEP_W'($urandom_range(1, 24));
            settle();
            write_keep(keep);
            repeat ($urandom_range(1, 3)) run_set();
            phase++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.operation = tkmc_pkg::OP_LOAD;
        item_ch.start_set = 1'b0;
        item_ch.principal_one = '0;
        item_ch.principal_two = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        steady = 1'b0;
        counted = 0;
        quiet_cycles = 0;
        board = new();

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_random();

        // Drain the last results, then let a few more cycles pass. Any stray word
        // that arrives in that time is caught by the monitor.
        settle();
        repeat (20) @(negedge clk);
        if (board.due.size() != 0)
        begin
            $error("%0d expected result words never arrived", board.due.size());
            board.failures++;
        end
        if (board.failures == 0)
            $display("top_k_mean_curvature_select verification clean");
        else
            $display("top_k_mean_curvature_select verification failed");
        $finish;
    end

endmodule
